// ----- src/ascii_log_crc32_frame_check_macros.svh -----
// Assertion macros for the frame checker
`ifndef ASCII_LOG_CRC32_FRAME_CHECK_MACROS_SVH
`define ASCII_LOG_CRC32_FRAME_CHECK_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset
`define ALCFC_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) \
    else $error("frame check assertion failed");

// Condition must never be seen outside reset
`define ALCFC_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) \
    else $error("frame check forbidden condition seen");

`else

`define ALCFC_ASSERT(lbl, ck, rn, prop)
`define ALCFC_NEVER(lbl, ck, rn, cond)

`endif

`endif

// ----- src/alcfc_pkg.sv -----
package alcfc_pkg;

  localparam int CRC_W = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 4;

  localparam logic [CRC_W-1:0] CRC_POLY_RESET = 32'hEDB8_8320;
  localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;
  localparam logic [BYTE_W-1:0] STAR = 8'h2A;
  localparam logic [CNT_W-1:0] HEX_MAX_DIGITS = 4'd8;

  // Frame parsing phase
  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX  = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  // Decoded hex character
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dec_t;

  function automatic hex_dec_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_dec_t d;
    logic [BYTE_W-1:0] diff;
    d    = '0;
    diff = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff  = c - 8'h30;
      d.ok  = 1'b1;
      d.val = diff[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff  = c - 8'h37;
      d.ok  = 1'b1;
      d.val = diff[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff  = c - 8'h57;
      d.ok  = 1'b1;
      d.val = diff[3:0];
    end
    return d;
  endfunction

endpackage

// ----- src/alcfc_crc_byte.sv -----
module alcfc_crc_byte (
  input  logic [alcfc_pkg::CRC_W-1:0]  crc_in,
  input  logic [alcfc_pkg::BYTE_W-1:0] data_in,
  input  logic [alcfc_pkg::CRC_W-1:0]  poly,
  output logic [alcfc_pkg::CRC_W-1:0]  crc_out
);

  logic [alcfc_pkg::CRC_W-1:0] t;

  // Reflected CRC, eight bit steps over the low byte
  always_comb begin
    t = {{(alcfc_pkg::CRC_W-alcfc_pkg::BYTE_W){1'b0}},
         crc_in[alcfc_pkg::BYTE_W-1:0] ^ data_in};
    for (int k = 0; k < alcfc_pkg::BYTE_W; k++) begin
      if (t[0]) begin
        t = (t >> 1) ^ poly;
      end else begin
        t = t >> 1;
      end
    end
    crc_out = (crc_in >> alcfc_pkg::BYTE_W) ^ t;
  end

endmodule

// ----- src/ascii_log_crc32_frame_check.sv -----
// A line feed that is accepted loads the result registers and sets out_valid.
// Throughput: one byte per cycle when not stalled; CRC update is one byte-wide XOR tree per cycle.
// Input stalls only while a result is held and the output side stalls.
// Reset (rst_n low, synchronous): frame state and output valid clear,
// polynomial returns to 0xEDB88320.
`include "ascii_log_crc32_frame_check_macros.svh"

module ascii_log_crc32_frame_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [alcfc_pkg::CRC_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [alcfc_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_crc_match,
  output logic [alcfc_pkg::CRC_W-1:0]       out_computed_crc,
  output logic [alcfc_pkg::CRC_W-1:0]       out_received_crc,
  output logic                              out_malformed
);

  logic [alcfc_pkg::CRC_W-1:0] poly_r;
  alcfc_pkg::phase_t           phase_r, phase_nxt;
  logic [alcfc_pkg::CRC_W-1:0] crc_r, crc_nxt;
  logic [alcfc_pkg::CRC_W-1:0] hex_r, hex_nxt;
  logic [alcfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic                        match_r;
  logic [alcfc_pkg::CRC_W-1:0] comp_r;
  logic [alcfc_pkg::CRC_W-1:0] recv_r;
  logic                        bad_r;

  logic                        in_acc;
  logic                        is_lf;
  logic                        bad;
  logic [alcfc_pkg::CRC_W-1:0] crc_upd;
  alcfc_pkg::hex_dec_t         hd;

  // Handshake
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign is_lf    = (in_rx_byte == alcfc_pkg::LINE_FEED);
  assign hd       = alcfc_pkg::hex_decode(in_rx_byte);
  assign bad      = ~((phase_r == alcfc_pkg::PH_HEX) || (phase_r == alcfc_pkg::PH_TAIL))
                    | (cnt_r == '0);

  alcfc_crc_byte u_crc_byte (
    .crc_in  (crc_r),
    .data_in (in_rx_byte),
    .poly    (poly_r),
    .crc_out (crc_upd)
  );

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      if (is_lf) begin
        phase_nxt = alcfc_pkg::PH_SYNC;
      end else begin
        unique case (phase_r)
          alcfc_pkg::PH_SYNC: phase_nxt = alcfc_pkg::PH_BODY;
          alcfc_pkg::PH_BODY: begin
            if (in_rx_byte == alcfc_pkg::STAR) phase_nxt = alcfc_pkg::PH_HEX;
          end
          alcfc_pkg::PH_HEX: begin
            if (!(hd.ok && cnt_r < alcfc_pkg::HEX_MAX_DIGITS)) begin
              phase_nxt = alcfc_pkg::PH_TAIL;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Running CRC and hex collection
  always_comb begin
    crc_nxt = crc_r;
    hex_nxt = hex_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      if (is_lf) begin
        crc_nxt = '0;
        hex_nxt = '0;
        cnt_nxt = '0;
      end else begin
        unique case (phase_r)
          alcfc_pkg::PH_BODY: begin
            if (in_rx_byte == alcfc_pkg::STAR) begin
              hex_nxt = '0;
              cnt_nxt = '0;
            end else begin
              crc_nxt = crc_upd;
            end
          end
          alcfc_pkg::PH_HEX: begin
            if (hd.ok && cnt_r < alcfc_pkg::HEX_MAX_DIGITS) begin
              hex_nxt = {hex_r[alcfc_pkg::CRC_W-5:0], hd.val};
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          default: begin
            crc_nxt = crc_r;
          end
        endcase
      end
    end
  end

  // Configuration and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= alcfc_pkg::CRC_POLY_RESET;
      phase_r <= alcfc_pkg::PH_SYNC;
      crc_r   <= '0;
      hex_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) poly_r <= cfg_wr_data;
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      hex_r   <= hex_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && is_lf) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_lf) begin
      match_r <= ~bad & (crc_r == hex_r);
      comp_r  <= crc_r;
      recv_r  <= hex_r;
      bad_r   <= bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_crc_match    = match_r;
  assign out_computed_crc = comp_r;
  assign out_received_crc = recv_r;
  assign out_malformed    = bad_r;

  // Checks
  `ALCFC_ASSERT(a_lf_gives_result, clk, rst_n, (in_acc && is_lf) |=> out_valid_r)
  `ALCFC_ASSERT(a_lf_clears_frame, clk, rst_n,
                (in_acc && is_lf) |=>
                (phase_r == alcfc_pkg::PH_SYNC && crc_r == '0 && cnt_r == '0))
  `ALCFC_NEVER(a_cnt_over, clk, rst_n, cnt_r > alcfc_pkg::HEX_MAX_DIGITS)
  `ALCFC_NEVER(a_cnt_phase, clk, rst_n,
               (cnt_r != '0) && (phase_r == alcfc_pkg::PH_SYNC || phase_r == alcfc_pkg::PH_BODY))
  `ALCFC_NEVER(a_match_bad, clk, rst_n, out_valid_r && match_r && bad_r)

endmodule
